// File: rtl/aled_pkg.sv
// ----------------------------------------------------------------------------
// aled_pkg
// Shared codes and defaults for the addressable LED frame driver.
// ----------------------------------------------------------------------------
package aled_pkg;

  localparam int MAX_LEDS_DEF  = 256;
  localparam int DUTY_BITS_DEF = 16;

  localparam int PW_W = 16;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SET1  = 2'd1;
  localparam logic [1:0] MODE_RGB   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] SLOT_G = 2'd0;
  localparam logic [1:0] SLOT_R = 2'd1;
  localparam logic [1:0] SLOT_B = 2'd2;

  localparam logic [1:0] PH_RESET = 2'd0;
  localparam logic [1:0] PH_IDLE  = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  localparam logic [1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [1:0] REG_RESET_TICKS = 2'd1;
  localparam logic [1:0] REG_ONE_DUTY    = 2'd2;
  localparam logic [1:0] REG_ZERO_DUTY   = 2'd3;

  localparam logic [8:0]  LED_COUNT_RST   = 9'd1;
  localparam logic [7:0]  RESET_TICKS_RST = 8'd10;
  localparam logic [15:0] ONE_DUTY_RST    = 16'd58;
  localparam logic [15:0] ZERO_DUTY_RST   = 16'd29;

  localparam logic [4:0] BITS_PER_TICK = 5'd24;

endpackage

// File: rtl/addressable_led_frame_driver.sv
// ----------------------------------------------------------------------------
// addressable_led_frame_driver
// Colour store and per-tick pulse width sequencer for a serial LED chain.
// ----------------------------------------------------------------------------
// Tick: 24 results, one a cycle from the cycle after start (zero tick), or
//   after one memory read per colour byte (data tick); busy ends with the
//   last word. A single channel write stores one byte, an rgb write three
//   and a clear three per LED in the chain, one byte at a time.
// Reset: synchronous; a clearing pass over all MAX_LEDS entries runs after
//   reset with busy high. The receiver cannot stall results.
module addressable_led_frame_driver
  import aled_pkg::*;
#(
  parameter int MAX_LEDS  = MAX_LEDS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      mode,
  input  logic [7:0]      led_index,
  input  logic [1:0]      color_slot,
  input  logic [7:0]      red_or_value,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output logic            result_strobe,
  output logic [PW_W-1:0] pulse_width,
  output logic            carries_data,
  output logic            last_of_tick
);

  localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int NW = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;
  localparam int AW = IW + 2;
  localparam int DW = (DUTY_BITS < PW_W) ? DUTY_BITS : PW_W;
  localparam logic [PW_W:0] DMASK = ((PW_W + 1)'(1) << DW) - (PW_W + 1)'(1);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_LEDS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_ZERO  = 3'd6;

  logic [2:0]      state;
  logic [8:0]      led_count;
  logic [7:0]      reset_ticks;
  logic [15:0]     one_duty;
  logic [15:0]     zero_duty;
  logic [1:0]      phase;
  logic [7:0]      reset_counter;
  logic [IW-1:0]   led_position;
  logic            dirty;
  logic [1:0]      slot;
  logic [2:0]      bit_cnt;
  logic [4:0]      zero_cnt;
  logic [IW-1:0]   clr_led;
  logic [NW-1:0]   clr_lim;
  logic            wr_rgb;
  logic            wr_ok;
  logic [IW-1:0]   wr_led;
  logic [7:0]      wr_val;
  logic [7:0]      wr_g;
  logic [7:0]      wr_b;
  logic [7:0]      rdata;
  logic [7:0]      store [4*MAX_LEDS];

  logic [NW-1:0]   eff_n;
  logic [NW-1:0]   led_ext;
  logic            led_ok;
  logic            accept;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [NW-1:0]   pos_next;
  logic [NW-1:0]   clr_next;
  logic            clr_done;
  logic [7:0]      rc_next;
  logic            cur_bit;

  assign eff_n    = (NW'(led_count) > MAX_N) ? MAX_N : NW'(led_count);
  assign led_ext  = NW'(led_index);
  assign led_ok   = led_ext < eff_n;
  assign accept   = start && !busy;
  assign busy     = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign pos_next = NW'(led_position) + NW'(1);
  assign clr_next = NW'(clr_led) + NW'(1);
  assign clr_done = (clr_lim == '0) || ((slot == SLOT_B) && (clr_next >= clr_lim));
  assign rc_next  = (reset_counter < 8'hFF) ? reset_counter + 8'd1 : reset_counter;
  assign cur_bit  = rdata[~bit_cnt];

  always_comb begin
    we    = 1'b0;
    waddr = {clr_led, slot};
    wdata = 8'd0;
    unique case (state)
      S_INIT, S_CLEAR: begin
        we = clr_lim != '0;
      end
      S_WRITE: begin
        we    = wr_ok;
        waddr = {wr_led, slot};
        wdata = wr_val;
        if (wr_rgb) begin
          case (slot)
            SLOT_G:  wdata = wr_g;
            SLOT_B:  wdata = wr_b;
            default: wdata = wr_val;
          endcase
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (state == S_READ) begin
      rdata <= store[{led_position, slot}];
    end
  end

  always_comb begin
    result_strobe = (state == S_EMIT) || (state == S_ZERO);
    carries_data  = state == S_EMIT;
    pulse_width   = '0;
    last_of_tick  = 1'b0;
    if (state == S_EMIT) begin
      pulse_width  = (cur_bit ? one_duty : zero_duty) & DMASK[PW_W-1:0];
      last_of_tick = (slot == SLOT_B) && (bit_cnt == 3'd7);
    end else if (state == S_ZERO) begin
      last_of_tick = zero_cnt == BITS_PER_TICK - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= LED_COUNT_RST;
      reset_ticks <= RESET_TICKS_RST;
      one_duty    <= ONE_DUTY_RST;
      zero_duty   <= ZERO_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LED_COUNT:   led_count   <= cfg_data[8:0];
        REG_RESET_TICKS: reset_ticks <= cfg_data[7:0];
        REG_ONE_DUTY:    one_duty    <= cfg_data;
        REG_ZERO_DUTY:   zero_duty   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_led <= led_ext[IW-1:0];
      wr_val <= red_or_value;
      wr_g   <= green;
      wr_b   <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      phase         <= PH_RESET;
      reset_counter <= '0;
      led_position  <= '0;
      dirty         <= 1'b0;
      slot          <= SLOT_G;
      bit_cnt       <= '0;
      zero_cnt      <= '0;
      clr_led       <= '0;
      clr_lim       <= MAX_N;
      wr_rgb        <= 1'b0;
      wr_ok         <= 1'b0;
    end else begin
      unique case (state)
        S_INIT, S_CLEAR: begin
          if (clr_done) begin
            state <= S_IDLE;
          end else if (slot == SLOT_B) begin
            slot    <= SLOT_G;
            clr_led <= clr_led + IW'(1);
          end else begin
            slot <= slot + 2'd1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_SET1: begin
                state  <= S_WRITE;
                wr_rgb <= 1'b0;
                wr_ok  <= led_ok && (color_slot <= SLOT_B);
                slot   <= color_slot;
                if (led_ok && (color_slot <= SLOT_B)) begin
                  dirty <= 1'b1;
                end
              end
              MODE_RGB: begin
                state  <= S_WRITE;
                wr_rgb <= 1'b1;
                wr_ok  <= led_ok;
                slot   <= SLOT_G;
                if (led_ok) begin
                  dirty <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                state   <= S_CLEAR;
                clr_led <= '0;
                clr_lim <= eff_n;
                slot    <= SLOT_G;
                dirty   <= 1'b1;
              end
              MODE_TICK: begin
                if (phase == PH_DATA) begin
                  state   <= S_READ;
                  slot    <= SLOT_G;
                  bit_cnt <= '0;
                end else begin
                  state    <= S_ZERO;
                  zero_cnt <= '0;
                  if (phase == PH_IDLE) begin
                    if (dirty) begin
                      dirty <= 1'b0;
                      phase <= PH_DATA;
                    end
                  end else begin
                    reset_counter <= rc_next;
                    if (rc_next >= reset_ticks) begin
                      led_position <= '0;
                      if (dirty) begin
                        dirty <= 1'b0;
                        phase <= PH_DATA;
                      end else begin
                        phase <= PH_IDLE;
                      end
                    end
                  end
                end
              end
            endcase
          end
        end
        S_WRITE: begin
          if (!wr_rgb || slot == SLOT_B) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 2'd1;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (slot == SLOT_B) begin
              state <= S_IDLE;
              if (pos_next >= eff_n) begin
                led_position  <= '0;
                reset_counter <= '0;
                phase         <= PH_RESET;
              end else begin
                led_position <= pos_next[IW-1:0];
              end
            end else begin
              slot  <= slot + 2'd1;
              state <= S_READ;
            end
          end
        end
        S_ZERO: begin
          zero_cnt <= zero_cnt + 5'd1;
          if (zero_cnt == BITS_PER_TICK - 5'd1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_word_in_tick: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result word outside a tick");
  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    carries_data |-> (phase == PH_DATA))
    else $error("data word outside data phase");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_tick) |=> !busy)
    else $error("busy held after last word of tick");
`endif

endmodule

// File: tb/sv/tb_addressable_led_frame_driver.sv
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_driver
// Self-checking bench for the LED frame driver. Colour writes and ticks are
// driven through the command port and registers through the write channel.
// A local copy of the colour store and phase sequencer predicts every pulse
// width word, and each word is checked in order as it is strobed out.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_driver
  import aled_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 3 * MAX_LEDS_DEF + 32;
  localparam int IDLE_PCT      = 28;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] idx;
    logic [1:0] slot;
    logic [7:0] rv;
    logic [7:0] g;
    logic [7:0] b;
  } led_cmd_t;

  typedef struct packed {
    logic [PW_W-1:0] width;
    logic            data;
    logic            last;
  } pulse_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  logic [1:0]      mode;
  logic [7:0]      led_index;
  logic [1:0]      color_slot;
  logic [7:0]      red_or_value;
  logic [7:0]      green;
  logic [7:0]      blue;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [15:0]     cfg_data;
  logic            result_strobe;
  logic [PW_W-1:0] pulse_width;
  logic            carries_data;
  logic            last_of_tick;

  // shadow of registers and sequencer state
  logic [8:0]  cfg_leds;
  logic [7:0]  cfg_latch;
  logic [15:0] cfg_one;
  logic [15:0] cfg_zero;
  logic [1:0]  cur_phase;
  logic [7:0]  latch_cnt;
  logic [8:0]  led_pos;
  logic        store_dirty;
  logic [7:0]  colour_store [3*MAX_LEDS_DEF];

  pulse_t pulse_q [$];
  pulse_t want;
  int     err_count   = 0;
  int     cycle_count = 0;
  bit     gaps_on;

  addressable_led_frame_driver i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[addressable_led_frame_driver] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pulse_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word pw=%0d data=%0b last=%0b",
                                  pulse_width, carries_data, last_of_tick));
      end else begin
        want = pulse_q.pop_front();
        if (pulse_width !== want.width)
          report_mismatch($sformatf("pulse_width %0d, want %0d", pulse_width, want.width));
        if (carries_data !== want.data)
          report_mismatch($sformatf("carries_data %0b, want %0b", carries_data, want.data));
        if (last_of_tick !== want.last)
          report_mismatch($sformatf("last_of_tick %0b, want %0b", last_of_tick, want.last));
      end
    end
  end

  function automatic int chain_len();
    return (cfg_leds > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(cfg_leds);
  endfunction

  task automatic init_model();
    cfg_leds    = LED_COUNT_RST;
    cfg_latch   = RESET_TICKS_RST;
    cfg_one     = ONE_DUTY_RST;
    cfg_zero    = ZERO_DUTY_RST;
    cur_phase   = PH_RESET;
    latch_cnt   = 8'd0;
    led_pos     = 9'd0;
    store_dirty = 1'b0;
    for (int i = 0; i < 3 * MAX_LEDS_DEF; i++) colour_store[i] = 8'd0;
  endtask

  // updates the store for writes; a tick queues its 24 pulse widths
  task automatic apply_command(input led_cmd_t c);
    int         n;
    int         pos;
    pulse_t     p;
    logic [7:0] byte_v;
    n = chain_len();
    case (c.mode)
      MODE_SET1: begin
        if (c.idx < n && c.slot != SLOT_NONE) begin
          colour_store[3 * c.idx + c.slot] = c.rv;
          store_dirty = 1'b1;
        end
      end
      MODE_RGB: begin
        if (c.idx < n) begin
          colour_store[3 * c.idx + SLOT_R] = c.rv;
          colour_store[3 * c.idx + SLOT_G] = c.g;
          colour_store[3 * c.idx + SLOT_B] = c.b;
          store_dirty = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < 3 * n; i++) colour_store[i] = 8'd0;
        store_dirty = 1'b1;
      end
      default: begin
        if (cur_phase == PH_DATA) begin
          pos = (led_pos < MAX_LEDS_DEF) ? int'(led_pos) : 0;
          for (int k = 0; k < 24; k++) begin
            byte_v  = colour_store[3 * pos + k / 8];
            p.width = byte_v[7 - k % 8] ? cfg_one : cfg_zero;
            p.data  = 1'b1;
            p.last  = (k == 23);
            pulse_q.push_back(p);
          end
          led_pos = 9'(pos + 1);
          if (led_pos >= n) begin
            led_pos   = 9'd0;
            latch_cnt = 8'd0;
            cur_phase = PH_RESET;
          end
        end else begin
          for (int k = 0; k < 24; k++) begin
            p.width = '0;
            p.data  = 1'b0;
            p.last  = (k == 23);
            pulse_q.push_back(p);
          end
          if (cur_phase == PH_IDLE) begin
            if (store_dirty) begin
              store_dirty = 1'b0;
              cur_phase   = PH_DATA;
            end
          end else begin
            if (latch_cnt < 8'hFF) latch_cnt++;
            if (latch_cnt >= cfg_latch) begin
              led_pos = 9'd0;
              if (store_dirty) begin
                store_dirty = 1'b0;
                cur_phase   = PH_DATA;
              end else begin
                cur_phase = PH_IDLE;
              end
            end
          end
        end
      end
    endcase
  endtask

  function automatic led_cmd_t cmd(input logic [1:0] m, input logic [7:0] idx,
                                   input logic [1:0] slot, input logic [7:0] rv,
                                   input logic [7:0] g, input logic [7:0] b);
    led_cmd_t c;
    c.mode = m;
    c.idx  = idx;
    c.slot = slot;
    c.rv   = rv;
    c.g    = g;
    c.b    = b;
    return c;
  endfunction

  function automatic led_cmd_t rand_cmd();
    led_cmd_t c;
    int       n;
    int       sel;
    n   = chain_len();
    sel = $urandom_range(99);
    c.mode = (sel < 55) ? MODE_TICK : (sel < 75) ? MODE_RGB :
             (sel < 95) ? MODE_SET1 : MODE_CLEAR;
    c.idx  = (n > 0 && $urandom_range(3) != 0) ? 8'($urandom_range(n - 1))
                                                : 8'($urandom_range(255));
    c.slot = ($urandom_range(7) == 0) ? SLOT_NONE : 2'($urandom_range(2));
    c.rv   = 8'($urandom);
    c.g    = 8'($urandom);
    c.b    = 8'($urandom);
    return c;
  endfunction

  // start is left high after acceptance; a gap or settle lowers it
  task automatic send_word(input led_cmd_t c);
    if (gaps_on)
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start        <= 1'b1;
    mode         <= c.mode;
    led_index    <= c.idx;
    color_slot   <= c.slot;
    red_or_value <= c.rv;
    green        <= c.g;
    blue         <= c.b;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(c);
  endtask

  task automatic send_ticks(input int count);
    repeat (count)
      send_word(cmd(MODE_TICK, 8'($urandom), 2'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom)));
  endtask

  // drain all words, then give a pending clear time to finish
  task automatic settle();
    start <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    if (gaps_on)
      while ($urandom_range(99) < IDLE_PCT) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LED_COUNT:   cfg_leds  = val[8:0];
      REG_RESET_TICKS: cfg_latch = val[7:0];
      REG_ONE_DUTY:    cfg_one   = val;
      REG_ZERO_DUTY:   cfg_zero  = val;
    endcase
  endtask

  task automatic set_config(input logic [15:0] leds, input logic [15:0] latch,
                            input logic [15:0] one_w, input logic [15:0] zero_w);
    settle();
    write_reg(REG_LED_COUNT, leds);
    write_reg(REG_RESET_TICKS, latch);
    write_reg(REG_ONE_DUTY, one_w);
    write_reg(REG_ZERO_DUTY, zero_w);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] leds, input logic [15:0] latch,
                           input logic [15:0] one_w, input logic [15:0] zero_w,
                           input int items);
    set_config(leds, latch, one_w, zero_w);
    repeat (items) send_word(rand_cmd());
  endtask

  // reset values: ten latch ticks, then one frame of LED 0
  task automatic test_default_frame();
    send_word(cmd(MODE_RGB, 8'd0, SLOT_G, 8'hFF, 8'h00, 8'h81));
    send_ticks(12);
  endtask

  // extreme duties, zero latch ticks, bad slot and out-of-range writes
  task automatic test_register_extremes();
    set_config(16'hFE03, 16'hFF00, 16'hFFFF, 16'h0000);
    send_word(cmd(MODE_SET1, 8'd1, SLOT_G, 8'h80, 8'h00, 8'h00));
    send_word(cmd(MODE_SET1, 8'd1, SLOT_R, 8'h01, 8'hFF, 8'hFF));
    send_word(cmd(MODE_SET1, 8'd1, SLOT_B, 8'h7F, 8'h00, 8'h00));
    send_word(cmd(MODE_SET1, 8'd0, SLOT_NONE, 8'hFF, 8'hFF, 8'hFF));
    send_word(cmd(MODE_RGB, 8'hFF, SLOT_G, 8'h55, 8'hAA, 8'hFF));
    send_word(cmd(MODE_RGB, 8'd2, SLOT_B, 8'hFF, 8'hAA, 8'h55));
    send_ticks(4);
  endtask

  // empty chain: writes ignored, clear still marks dirty, LED 0 sent once
  task automatic test_zero_count();
    set_config(16'd0, 16'd1, ONE_DUTY_RST, ZERO_DUTY_RST);
    send_word(cmd(MODE_RGB, 8'd0, SLOT_G, 8'h12, 8'h34, 8'h56));
    send_word(cmd(MODE_CLEAR, 8'd0, SLOT_G, 8'h00, 8'h00, 8'h00));
    send_ticks(3);
  endtask

  task automatic test_random_traffic();
    gaps_on = 1'b1;
    run_phase(16'($urandom_range(8, 2)), 16'($urandom_range(4, 1)),
              16'($urandom), 16'($urandom), 30);
    run_phase(16'd1, 16'd0, 16'hFFFF, 16'd0, 25);
    run_phase(16'd5, 16'd255, 16'($urandom), 16'($urandom), 25);
    run_phase(16'($urandom_range(12, 1)), 16'($urandom_range(3, 1)),
              16'd0, 16'hFFFF, 30);
  endtask

  // full-length chain, back-to-back words
  task automatic test_long_chain();
    gaps_on = 1'b0;
    run_phase(16'd511, 16'd1, 16'($urandom), 16'($urandom), 25);
    run_phase(16'd256, 16'd2, 16'($urandom), 16'($urandom), 15);
    gaps_on = 1'b1;
  endtask

  initial begin
    init_model();
    gaps_on      = 1'b1;
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= MODE_TICK;
    led_index    <= 8'd0;
    color_slot   <= SLOT_G;
    red_or_value <= 8'd0;
    green        <= 8'd0;
    blue         <= 8'd0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_LED_COUNT;
    cfg_data     <= 16'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_default_frame();
    test_register_extremes();
    test_zero_count();
    test_random_traffic();
    test_long_chain();
    settle();
    if (err_count == 0) begin
      $display("[addressable_led_frame_driver] OK");
    end else begin
      $display("[addressable_led_frame_driver] ERROR");
    end
    $finish;
  end

endmodule
